[sv/mtrg_pkg.sv]
// ----------------------------------------------------------------------------
// MT19937 generator package
// Shared constants, codes, state type and the tempering function of the
// 32-bit Mersenne Twister generator.
// ----------------------------------------------------------------------------
package mtrg_pkg;

    localparam int WORD_W          = 32;
    localparam int STATE_WORDS_DEF = 624;
    localparam int SHIFT_OFFSET    = 397;

    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;

    typedef enum logic [1:0] {
        FN_SEED  = 2'd0,
        FN_RAW   = 2'd1,
        FN_RANGE = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_EMPTY    = 2'd1,
        STS_UNSEEDED = 2'd2,
        STS_RSVD     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_WR,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_DRAW_RK,
        ST_DRAW_RN,
        ST_DRAW_RF,
        ST_DRAW_WR,
        ST_TEMPER,
        ST_MOD_RUN,
        ST_DONE
    } t_state;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

[sv/mtrg_ring.sv]
// ----------------------------------------------------------------------------
// MT19937 state ring
// Simple dual-port memory holding the twist state, one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module mtrg_ring #(
    parameter int DEPTH = mtrg_pkg::STATE_WORDS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [mtrg_pkg::WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [mtrg_pkg::WORD_W-1:0] o_rdata
);
    import mtrg_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/mtrg_mod.sv]
// ----------------------------------------------------------------------------
// MT19937 remainder unit
// Restoring remainder of a 32-bit dividend by a nonzero 32-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtrg_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mtrg_pkg::WORD_W-1:0] i_dividend,
    input  logic [mtrg_pkg::WORD_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [mtrg_pkg::WORD_W-1:0] o_rem
);
    import mtrg_pkg::*;

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_dvd;
    logic [WORD_W-1:0] r_div;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;

    assign trial = {r_rem, r_dvd[WORD_W-1]};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WORD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[sv/mtrg_seq.sv]
// ----------------------------------------------------------------------------
// MT19937 sequencer
// Control state machine and datapath: seeding recurrence with a shared
// multiplier, twist of one word, tempering, and the output register.
// ----------------------------------------------------------------------------
module mtrg_seq #(
    parameter int STATE_WORDS = mtrg_pkg::STATE_WORDS_DEF,
    parameter int IDX_W       = $clog2(STATE_WORDS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_func,
    input  logic [mtrg_pkg::WORD_W-1:0] i_seed_value,
    input  logic [mtrg_pkg::WORD_W-1:0] i_range_low,
    input  logic [mtrg_pkg::WORD_W-1:0] i_range_high,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mtrg_pkg::WORD_W-1:0] o_value,
    output logic [1:0]                  o_status,
    output logic                        o_ring_we,
    output logic [IDX_W-1:0]            o_ring_waddr,
    output logic [mtrg_pkg::WORD_W-1:0] o_ring_wdata,
    output logic [IDX_W-1:0]            o_ring_raddr,
    input  logic [mtrg_pkg::WORD_W-1:0] i_ring_rdata,
    output logic                        o_mod_start,
    output logic [mtrg_pkg::WORD_W-1:0] o_mod_dividend,
    output logic [mtrg_pkg::WORD_W-1:0] o_mod_divisor,
    input  logic                        i_mod_done,
    input  logic [mtrg_pkg::WORD_W-1:0] i_mod_rem
);
    import mtrg_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

    t_state            r_state;
    t_state            n_state;
    logic              r_seeded;
    logic [IDX_W-1:0]  r_index;
    logic [IDX_W-1:0]  r_count;
    logic [1:0]        r_func;
    logic [WORD_W-1:0] r_low;
    logic [WORD_W-1:0] r_high;
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_prod;
    logic [WORD_W-1:0] r_res_value;
    logic [1:0]        r_res_status;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_value;
    logic [1:0]        r_out_status;

    logic              accept;
    logic              out_free;
    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W:0]    far_sum;
    logic [IDX_W-1:0]  idx_far;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] twisted;
    logic [WORD_W-1:0] tempered;
    logic [WORD_W-1:0] span;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign idx_next = (r_index == LAST_IDX) ? '0 : r_index + 1'b1;
    assign far_sum  = {1'b0, r_index} + (IDX_W+1)'(SHIFT_OFFSET);
    assign idx_far  = (far_sum >= (IDX_W+1)'(STATE_WORDS)) ?
                      IDX_W'(far_sum - (IDX_W+1)'(STATE_WORDS)) : far_sum[IDX_W-1:0];
    assign mix      = r_word ^ (r_word >> 30);
    assign twisted  = i_ring_rdata ^ ({1'b0, r_word[WORD_W-1:1]} ^
                      (r_word[0] ? TWIST_MATRIX : '0));
    assign tempered = temper(r_word);
    assign span     = r_high - r_low;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_func == FN_SEED) begin
                        n_state = ST_SEED_WR;
                    end else if ((i_func inside {FN_RAW, FN_RANGE}) && r_seeded) begin
                        n_state = ST_DRAW_RK;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SEED_WR:  n_state = (r_count == LAST_IDX) ? ST_DONE : ST_SEED_MUL;
            ST_SEED_MUL: n_state = ST_SEED_ADD;
            ST_SEED_ADD: n_state = ST_SEED_WR;
            ST_DRAW_RK:  n_state = ST_DRAW_RN;
            ST_DRAW_RN:  n_state = ST_DRAW_RF;
            ST_DRAW_RF:  n_state = ST_DRAW_WR;
            ST_DRAW_WR:  n_state = ST_TEMPER;
            ST_TEMPER: begin
                if (r_func == FN_RANGE && span != '0) begin
                    n_state = ST_MOD_RUN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MOD_RUN:  n_state = i_mod_done ? ST_DONE : ST_MOD_RUN;
            ST_DONE:     n_state = out_free ? ST_IDLE : ST_DONE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ring_we      = 1'b0;
        o_ring_waddr   = r_count;
        o_ring_wdata   = r_word;
        o_ring_raddr   = r_index;
        o_mod_start    = 1'b0;
        case (r_state)
            ST_SEED_WR: begin
                o_ring_we = 1'b1;
            end
            ST_DRAW_RN: begin
                o_ring_raddr = idx_next;
            end
            ST_DRAW_RF: begin
                o_ring_raddr = idx_far;
            end
            ST_DRAW_WR: begin
                o_ring_we    = 1'b1;
                o_ring_waddr = r_index;
                o_ring_wdata = twisted;
            end
            ST_TEMPER: begin
                o_mod_start = (r_func == FN_RANGE) && (span != '0);
            end
            default: begin
                o_ring_we = 1'b0;
            end
        endcase
    end

    assign o_mod_dividend = tempered;
    assign o_mod_divisor  = span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_seeded <= 1'b0;
            r_index  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SEED_WR && r_count == LAST_IDX) begin
                r_seeded <= 1'b1;
                r_index  <= '0;
            end else if (r_state == ST_DRAW_WR) begin
                r_index <= idx_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_func       <= i_func;
                    r_low        <= i_range_low;
                    r_high       <= i_range_high;
                    r_word       <= i_seed_value;
                    r_count      <= '0;
                    r_res_value  <= '0;
                    r_res_status <= ((i_func inside {FN_RAW, FN_RANGE}) && !r_seeded) ?
                                    STS_UNSEEDED : STS_OK;
                end
            end
            ST_SEED_WR: begin
                r_count <= r_count + 1'b1;
            end
            ST_SEED_MUL: begin
                r_prod <= WORD_W'(mix * SEED_MULT);
            end
            ST_SEED_ADD: begin
                r_word <= r_prod + WORD_W'(r_count);
            end
            ST_DRAW_RN: begin
                r_word <= i_ring_rdata;
            end
            ST_DRAW_RF: begin
                r_word <= {r_word[WORD_W-1], i_ring_rdata[WORD_W-2:0]};
            end
            ST_DRAW_WR: begin
                r_word <= twisted;
            end
            ST_TEMPER: begin
                if (r_func == FN_RAW) begin
                    r_res_value <= tempered;
                end else if (span == '0) begin
                    r_res_status <= STS_EMPTY;
                end
            end
            ST_MOD_RUN: begin
                if (i_mod_done) begin
                    r_res_value <= i_mod_rem + r_low;
                end
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_status    = r_out_status;

endmodule

[sv/mt19937_random_generator_unit.sv]
// ----------------------------------------------------------------------------
// MT19937 random generator unit
// 32-bit Mersenne Twister with a 624-word state ring, seeding, raw draws
// and draws reduced to a range.
//
//   Channel  Direction  Handshake                 Beat fields
//   in       input      i_in_valid / o_in_stall   func, seed_value, range_low,
//                                                 range_high
//   out      output     o_out_valid / i_out_stall value, status
//
// A raw draw reads the current, next and far words on the single read port
// of the ring, writes the twisted word back, tempers it and registers the result.
// A range draw with a nonzero span adds a pass through the one-bit-per-cycle
// remainder unit. A seed writes each word of the recurrence, then forms the
// next one in the multiply and add steps of the recurrence.
// Reset clears the index and the seeded flag; the ring itself is not cleared.
// The next beat is taken while a finished result waits in the output register.
// ----------------------------------------------------------------------------
module mt19937_random_generator_unit #(
    parameter int STATE_WORDS = mtrg_pkg::STATE_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_func,
    input  logic [mtrg_pkg::WORD_W-1:0] i_seed_value,
    input  logic [mtrg_pkg::WORD_W-1:0] i_range_low,
    input  logic [mtrg_pkg::WORD_W-1:0] i_range_high,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mtrg_pkg::WORD_W-1:0] o_value,
    output logic [1:0]                  o_status
);
    import mtrg_pkg::*;

    localparam int IDX_W = $clog2(STATE_WORDS);

    logic              ring_we;
    logic [IDX_W-1:0]  ring_waddr;
    logic [WORD_W-1:0] ring_wdata;
    logic [IDX_W-1:0]  ring_raddr;
    logic [WORD_W-1:0] ring_rdata;
    logic              mod_start;
    logic [WORD_W-1:0] mod_dividend;
    logic [WORD_W-1:0] mod_divisor;
    logic              mod_done;
    logic [WORD_W-1:0] mod_rem;

    mtrg_ring #(
        .DEPTH (STATE_WORDS),
        .AW    (IDX_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    mtrg_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (mod_divisor),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    mtrg_seq #(
        .STATE_WORDS (STATE_WORDS),
        .IDX_W       (IDX_W)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_seed_value   (i_seed_value),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_value        (o_value),
        .o_status       (o_status),
        .o_ring_we      (ring_we),
        .o_ring_waddr   (ring_waddr),
        .o_ring_wdata   (ring_wdata),
        .o_ring_raddr   (ring_raddr),
        .i_ring_rdata   (ring_rdata),
        .o_mod_start    (mod_start),
        .o_mod_dividend (mod_dividend),
        .o_mod_divisor  (mod_divisor),
        .i_mod_done     (mod_done),
        .i_mod_rem      (mod_rem)
    );

endmodule

[sv/mtrg_checker.sv]
// ----------------------------------------------------------------------------
// MT19937 port checker
// Concurrent checks on the ports of the generator unit, bound to the top.
// ----------------------------------------------------------------------------
module mtrg_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [mtrg_pkg::WORD_W-1:0] o_value,
    input logic [1:0]                  o_status
);
    import mtrg_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value) && $stable(o_status))
        else $error("Stalled output beat changed.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != STS_RSVD)
        else $error("Reserved status code on output.");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STS_OK |-> o_value == '0)
        else $error("Error beat carries a nonzero value.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Input not stalled after an accepted beat.");

endmodule

bind mt19937_random_generator_unit mtrg_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_value     (o_value),
    .o_status    (o_status)
);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MT19937 random generator unit testbench
// Drives seed, raw draw, range draw and no-function beats through the
// valid/stall input channel with random bursts and gaps, stalls the output
// on a shifting pattern, and checks every result beat against a Mersenne
// Twister ring kept inside the testbench.
// ----------------------------------------------------------------------------
module testbench;
    import mtrg_pkg::*;

    localparam int RING_WORDS = STATE_WORDS_DEF;
    localparam int HOLD_CYCLES = 2500;

    typedef struct {
        t_func             func;
        logic [WORD_W-1:0] seed_value;
        logic [WORD_W-1:0] range_low;
        logic [WORD_W-1:0] range_high;
        bit                drain_first;
    } t_gen_request;

    typedef struct {
        logic [WORD_W-1:0] value;
        t_status           status;
    } t_gen_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_func = FN_NONE;
    logic [WORD_W-1:0] i_seed_value = '0;
    logic [WORD_W-1:0] i_range_low = '0;
    logic [WORD_W-1:0] i_range_high = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [WORD_W-1:0] o_value;
    logic [1:0]        o_status;

    t_gen_request gen_requests[$];
    t_gen_result  pending_results[$];
    t_gen_request cur_request;

    logic [WORD_W-1:0] mt_ring [0:RING_WORDS-1];
    int unsigned       mt_index = 0;
    bit                mt_seeded = 1'b0;

    int unsigned n_in = 0;
    int unsigned n_out = 0;
    int unsigned n_errors = 0;
    int unsigned n_requests = 0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    int unsigned holds_done = 0;
    int unsigned mode_left = 0;
    int unsigned stall_mode = 0;
    int unsigned rx_cycles = 0;

    mt19937_random_generator_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_seed_value (i_seed_value),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_status     (o_status)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #100_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic void mt_seed_ring(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] w;
        w = s;
        mt_ring[0] = w;
        for (int i = 1; i < RING_WORDS; i++) begin
            w = (w ^ (w >> 30)) * SEED_MULT + i;
            mt_ring[i] = w;
        end
        mt_index = 0;
        mt_seeded = 1'b1;
    endfunction

    function automatic logic [WORD_W-1:0] mt_draw_tempered();
        int unsigned       k;
        int unsigned       nx;
        int unsigned       fr;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] xa;
        logic [WORD_W-1:0] y;
        k = mt_index;
        nx = (k + 1) % RING_WORDS;
        fr = (k + SHIFT_OFFSET) % RING_WORDS;
        x = {mt_ring[k][WORD_W-1], mt_ring[nx][WORD_W-2:0]};
        xa = x >> 1;
        if (x[0]) begin
            xa = xa ^ TWIST_MATRIX;
        end
        x = mt_ring[fr] ^ xa;
        mt_ring[k] = x;
        mt_index = nx;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic t_gen_result mt_compute_result(input t_gen_request r);
        t_gen_result       res;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] span;
        res.value = '0;
        res.status = STS_OK;
        case (r.func)
            FN_SEED: begin
                mt_seed_ring(r.seed_value);
            end
            FN_RAW, FN_RANGE: begin
                if (!mt_seeded) begin
                    res.status = STS_UNSEEDED;
                end else begin
                    z = mt_draw_tempered();
                    if (r.func == FN_RAW) begin
                        res.value = z;
                    end else begin
                        span = r.range_high - r.range_low;
                        if (span == '0) begin
                            res.status = STS_EMPTY;
                        end else begin
                            res.value = (z % span) + r.range_low;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic add_request(input t_func f, input logic [WORD_W-1:0] s,
                               input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                               input bit drain);
        t_gen_request r;
        r.func = f;
        r.seed_value = s;
        r.range_low = lo;
        r.range_high = hi;
        r.drain_first = drain;
        gen_requests.push_back(r);
    endtask

    function automatic t_gen_request random_draw_request();
        t_gen_request r;
        int unsigned  pick;
        r.seed_value = $urandom;
        r.range_low = $urandom;
        r.range_high = $urandom;
        r.drain_first = ($urandom_range(0, 199) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            r.func = FN_NONE;
        end else if (pick < 50) begin
            r.func = FN_RAW;
        end else begin
            r.func = FN_RANGE;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: r.range_high = r.range_low + $urandom_range(1, 1000);
                5: r.range_high = r.range_low;
                6: r.range_high = r.range_low - $urandom_range(1, 1000);
                7: r.range_high = r.range_low + (32'h8000_0000 | $urandom);
                default: begin
                end
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        t_gen_request nb;
        int unsigned  taken;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            taken = n_in;
            if (i_in_valid && !o_in_stall) begin
                pending_results.push_back(mt_compute_result(cur_request));
                taken = n_in + 1;
                n_in <= taken;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (gen_requests.size() == 0 ||
                             (gen_requests[0].drain_first && n_out != taken)) begin
                    i_in_valid <= 1'b0;
                end else begin
                    nb = gen_requests.pop_front();
                    cur_request = nb;
                    i_in_valid <= 1'b1;
                    i_func <= nb.func;
                    i_seed_value <= nb.seed_value;
                    i_range_low <= nb.range_low;
                    i_range_high <= nb.range_high;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            rx_cycles++;
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (holds_done < 2 && n_in >= 400 * (holds_done + 1)) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(20, 200);
                    stall_mode = $urandom_range(0, 3);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= rx_cycles[2];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_gen_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_out <= n_out + 1;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected, value %h",
                                          o_value));
            end else begin
                e = pending_results.pop_front();
                if (o_value !== e.value) begin
                    report_mismatch($sformatf("value %h, expected %h", o_value, e.value));
                end
                if (o_status !== e.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d", o_status,
                                              e.status));
                end
            end
        end
    end

    initial begin
        int unsigned seg;
        int unsigned seg_len;
        int unsigned n_directed;

        add_request(FN_RAW, $urandom, $urandom, $urandom, 1'b0);
        add_request(FN_RANGE, $urandom, 32'd0, 32'd100, 1'b0);
        add_request(FN_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        add_request(FN_SEED, 32'h0000_0000, 32'd0, 32'd0, 1'b0);
        add_request(FN_RAW, 32'd0, 32'd0, 32'd0, 1'b0);
        add_request(FN_RANGE, 32'd0, 32'h0000_0000, 32'hffff_ffff, 1'b0);
        add_request(FN_RANGE, 32'd0, 32'd5, 32'd5, 1'b0);
        add_request(FN_RANGE, 32'd0, 32'hffff_ffff, 32'h0000_0000, 1'b0);
        add_request(FN_RANGE, 32'd0, 32'd10, 32'd3, 1'b0);
        add_request(FN_RANGE, 32'd0, 32'd0, 32'd1, 1'b0);
        add_request(FN_NONE, $urandom, $urandom, $urandom, 1'b0);
        add_request(FN_RAW, 32'd0, 32'd0, 32'd0, 1'b0);
        add_request(FN_SEED, 32'hffff_ffff, 32'd0, 32'd0, 1'b1);
        add_request(FN_RAW, 32'd0, 32'd0, 32'd0, 1'b0);
        add_request(FN_RANGE, 32'd0, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        add_request(FN_RANGE, 32'd0, 32'hffff_fff0, 32'hffff_ffff, 1'b0);
        add_request(FN_SEED, 32'd5489, 32'd0, 32'd0, 1'b0);
        add_request(FN_RAW, 32'd0, 32'd0, 32'd0, 1'b0);
        add_request(FN_RAW, 32'd0, 32'd0, 32'd0, 1'b0);
        n_directed = gen_requests.size();

        seg = 0;
        while (gen_requests.size() < n_directed + 1100) begin
            add_request(FN_SEED, $urandom, $urandom, $urandom, $urandom_range(0, 3) == 0);
            seg_len = (seg == 1) ? 700 : $urandom_range(10, 150);
            repeat (seg_len) gen_requests.push_back(random_draw_request());
            seg++;
        end
        n_requests = gen_requests.size();

        wait (n_in == n_requests && n_out == n_in);
        repeat (100) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));
        end
        if (n_errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
